[sv/r2fft_pkg.sv]
// package: widths, types, twiddle table builder and helper functions
`timescale 1ns / 1ps
package r2fft_pkg;

  localparam int LOG_MAX = 6;
  localparam int PTS     = 1 << LOG_MAX;
  localparam int SMP_W   = 16;
  localparam int DAT_W   = 23;
  localparam int TW_W    = 19;
  localparam int TW_N    = PTS / 2;
  localparam int TW_AW   = LOG_MAX - 1;
  localparam int PROD_W  = DAT_W + TW_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int TW_FRAC = 17;
  localparam int PR_W    = ACC_W - TW_FRAC;
  localparam int SUM_W   = PR_W + 1;
  localparam int CNT_W   = LOG_MAX + 1;
  localparam int LB_W    = 3;

  // register indexes of the configuration port
  localparam logic CFG_LOG2_SIZE = 1'b0;
  localparam logic CFG_INV_MODE  = 1'b1;

  typedef logic signed [DAT_W-1:0] dat_t;
  typedef logic signed [TW_W-1:0]  tw_t;
  typedef tw_t tw_tab_t [TW_N];

  // control of the shared butterfly unit
  typedef struct packed {
    logic       en;
    logic [1:0] step;
  } bfly_ctrl_t;

  // saturate a butterfly sum to the stored width
  function automatic dat_t sat_dat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (DAT_W - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    if (v > hi) return dat_t'(hi);
    if (v < lo) return dat_t'(lo);
    return dat_t'(v);
  endfunction

  // reverse the low nb bits of i
  function automatic logic [LOG_MAX-1:0] bit_rev(input logic [LOG_MAX-1:0] i,
                                                input logic [LB_W-1:0] nb);
    logic [LOG_MAX-1:0] r;
    for (int b = 0; b < LOG_MAX; b++) r[b] = i[LOG_MAX-1-b];
    return r >> (LB_W'(LOG_MAX) - nb);
  endfunction

  // q31 series value to 17 fractional bits
  function automatic tw_t q31_to_q17(input longint v);
    longint t;
    t = (v < 0) ? 64'sd0 : v;
    return tw_t'((t + 64'sd8192) >>> 14);
  endfunction

  // floor quotient of the series terms, shift and subtract
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos or sin of angle index j over a full turn of PTS points
  function automatic tw_tab_t build_tab(input bit want_sin);
    tw_tab_t tab;
    longint unsigned x, tc, ts, m;
    longint sc, ss;
    bit mirror;
    for (int j = 0; j < TW_N; j++) begin
      mirror = (4 * j) > PTS;
      m  = mirror ? longint'(TW_N - j) : longint'(j);
      x  = ((64'hC90FDAA2216 * 4 * m) + (64'd1 << (LOG_MAX + 11))) >> (LOG_MAX + 12);
      sc = 64'sd1 <<< 31;
      ss = longint'(x);
      tc = 64'd1 << 31;
      ts = x;
      for (int n = 1; n <= 10; n++) begin
        tc = udiv((((tc * x) >> 31) * x) >> 31, longint'((2 * n - 1) * (2 * n)));
        ts = udiv((((ts * x) >> 31) * x) >> 31, longint'((2 * n) * (2 * n + 1)));
        if (n[0]) begin
          sc = sc - longint'(tc);
          ss = ss - longint'(ts);
        end else begin
          sc = sc + longint'(tc);
          ss = ss + longint'(ts);
        end
      end
      if (want_sin) tab[j] = q31_to_q17(ss);
      else tab[j] = mirror ? -q31_to_q17(sc) : q31_to_q17(sc);
    end
    return tab;
  endfunction

endpackage

[sv/r2fft_in_if.sv]
// sample input channel
`timescale 1ns / 1ps
interface r2fft_in_if;
  import r2fft_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample_re;
  logic signed [SMP_W-1:0] sample_im;
  modport source (output valid, sample_re, sample_im, input ready);
  modport sink   (input valid, sample_re, sample_im, output ready);
endinterface

[sv/r2fft_out_if.sv]
// bin output channel
`timescale 1ns / 1ps
interface r2fft_out_if;
  import r2fft_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DAT_W-1:0] bin_re;
  logic signed [DAT_W-1:0] bin_im;
  logic [LOG_MAX-1:0]      bin_index;
  logic                    last_bin;
  modport source (output valid, bin_re, bin_im, bin_index, last_bin, input ready);
  modport sink   (input valid, bin_re, bin_im, bin_index, last_bin, output ready);
endinterface

[sv/radix2_fft_engine_top.sv]
// Radix-2 FFT engine. Takes N = 2^L complex Q1.15 samples, one beat each, while
// ready; once the frame is full it does a bit-reverse pass, then L*N/2
// butterflies on one shared multiplier, each a read, four multiply steps and
// two writes into a single-write-port work memory, then returns N bins in
// natural order, last_bin on the final one. The input is not ready from frame
// completion until the last bin is taken. Inverse mode conjugates the twiddles
// and scales by 1/N with rounding on the way out.
`timescale 1ns / 1ps
module radix2_fft_engine_top
  import r2fft_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LB_W-1:0]    cfg_data,
  r2fft_in_if.sink           in_s,
  r2fft_out_if.source        out_s
);

  typedef enum logic [3:0] {
    S_IDLE, S_SW_RD, S_SW_WA, S_SW_WB, S_BF_RD, S_BF_MAC, S_BF_WA, S_BF_WB,
    S_EM_RD, S_EM_LD, S_EM_OUT
  } state_t;

  localparam tw_tab_t COS_TAB = build_tab(1'b0);
  localparam tw_tab_t SIN_TAB = build_tab(1'b1);

  state_t              state_r;
  logic [LB_W-1:0]     log2_size_r;
  logic                inv_mode_r;
  logic [CNT_W-1:0]    load_cnt_r;
  logic [LB_W-1:0]     bits_r;
  logic                inv_r;
  logic [LOG_MAX-1:0]  idx_r;
  logic [LB_W-1:0]     stage_r;
  logic [1:0]          step_r;
  logic                out_valid_r;
  dat_t                bin_re_r;
  dat_t                bin_im_r;
  logic [LOG_MAX-1:0]  bin_index_r;
  logic                last_bin_r;

  logic [2*DAT_W-1:0]  mem [PTS];
  logic [2*DAT_W-1:0]  rd_a_r;
  logic [2*DAT_W-1:0]  rd_b_r;
  logic                rd_en;
  logic [LOG_MAX-1:0]  raddr_a;
  logic [LOG_MAX-1:0]  raddr_b;
  logic                we;
  logic [LOG_MAX-1:0]  waddr;
  logic [2*DAT_W-1:0]  wdata;

  logic [LB_W-1:0]     bits_c;
  logic [CNT_W-1:0]    cnt_inc;
  logic                accept;
  logic [LOG_MAX-1:0]  nmask;
  logic [LOG_MAX-1:0]  rev;
  logic [LOG_MAX-1:0]  half;
  logic [LOG_MAX-1:0]  kmask;
  logic [LOG_MAX-1:0]  bf_a;
  logic [LOG_MAX-1:0]  bf_b;
  logic [TW_AW-1:0]    tw_idx;
  tw_t                 tw_re;
  tw_t                 tw_im;
  bfly_ctrl_t          bctl;
  dat_t                sum_re, sum_im, dif_re, dif_im;
  logic signed [DAT_W:0] sc_re, sc_im;

  // size clamp and frame completion test
  always_comb begin
    bits_c = log2_size_r;
    if (log2_size_r == '0) bits_c = LB_W'(1);
    else if (log2_size_r > LB_W'(LOG_MAX)) bits_c = LB_W'(LOG_MAX);
  end
  assign cnt_inc = load_cnt_r + CNT_W'(1);
  assign accept  = in_s.valid && in_s.ready;

  // address generation for swap and butterfly passes
  assign nmask  = LOG_MAX'((CNT_W'(1) << bits_r) - CNT_W'(1));
  assign rev    = bit_rev(idx_r, bits_r);
  assign half   = LOG_MAX'(1) << stage_r;
  assign kmask  = half - LOG_MAX'(1);
  assign bf_a   = ((idx_r & ~kmask) << 1) | (idx_r & kmask);
  assign bf_b   = bf_a | half;
  assign tw_idx = TW_AW'((idx_r & kmask) << (LB_W'(LOG_MAX - 1) - stage_r));
  assign tw_re  = COS_TAB[tw_idx];
  assign tw_im  = inv_r ? SIN_TAB[tw_idx] : -SIN_TAB[tw_idx];

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    raddr_a = idx_r;
    raddr_b = rev;
    we      = 1'b0;
    waddr   = idx_r;
    wdata   = rd_b_r;
    case (state_r)
      S_IDLE: begin
        we    = accept;
        waddr = load_cnt_r[LOG_MAX-1:0];
        wdata = {DAT_W'(in_s.sample_re), DAT_W'(in_s.sample_im)};
      end
      S_SW_RD: rd_en = 1'b1;
      S_SW_WA: we = 1'b1;
      S_SW_WB: begin
        we    = 1'b1;
        waddr = rev;
        wdata = rd_a_r;
      end
      S_BF_RD: begin
        rd_en   = 1'b1;
        raddr_a = bf_a;
        raddr_b = bf_b;
      end
      S_BF_WA: begin
        we    = 1'b1;
        waddr = bf_a;
        wdata = {sum_re, sum_im};
      end
      S_BF_WB: begin
        we    = 1'b1;
        waddr = bf_b;
        wdata = {dif_re, dif_im};
      end
      S_EM_RD: rd_en = 1'b1;
      default: rd_en = 1'b0;
    endcase
  end

  // work memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  assign bctl.en   = (state_r == S_BF_MAC);
  assign bctl.step = step_r;

  r2fft_bfly u_bfly (
    .clk    (clk),
    .ctrl   (bctl),
    .ev_re  (dat_t'(rd_a_r[2*DAT_W-1:DAT_W])),
    .ev_im  (dat_t'(rd_a_r[DAT_W-1:0])),
    .odd_re (dat_t'(rd_b_r[2*DAT_W-1:DAT_W])),
    .odd_im (dat_t'(rd_b_r[DAT_W-1:0])),
    .tw_re  (tw_re),
    .tw_im  (tw_im),
    .sum_re (sum_re),
    .sum_im (sum_im),
    .dif_re (dif_re),
    .dif_im (dif_im)
  );

  // inverse scaling on the way out
  assign sc_re = ((DAT_W+1)'(signed'(rd_a_r[2*DAT_W-1:DAT_W]))
                 + ((DAT_W+1)'(1) <<< (bits_r - LB_W'(1)))) >>> bits_r;
  assign sc_im = ((DAT_W+1)'(signed'(rd_a_r[DAT_W-1:0]))
                 + ((DAT_W+1)'(1) <<< (bits_r - LB_W'(1)))) >>> bits_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      log2_size_r <= LB_W'(LOG_MAX);
      inv_mode_r  <= 1'b0;
      load_cnt_r  <= '0;
      bits_r      <= LB_W'(1);
      inv_r       <= 1'b0;
      idx_r       <= '0;
      stage_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LOG2_SIZE) log2_size_r <= cfg_data;
        else inv_mode_r <= cfg_data[0];
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (cnt_inc >= (CNT_W'(1) << bits_c)) begin
              load_cnt_r <= '0;
              bits_r     <= bits_c;
              inv_r      <= inv_mode_r;
              idx_r      <= '0;
              state_r    <= S_SW_RD;
            end else begin
              load_cnt_r <= cnt_inc;
            end
          end
        end
        S_SW_RD: begin
          if (idx_r < rev) state_r <= S_SW_WA;
          else if (idx_r == nmask) begin
            idx_r   <= '0;
            stage_r <= '0;
            state_r <= S_BF_RD;
          end else idx_r <= idx_r + LOG_MAX'(1);
        end
        S_SW_WA: state_r <= S_SW_WB;
        S_SW_WB: begin
          idx_r   <= idx_r + LOG_MAX'(1);
          state_r <= S_SW_RD;
        end
        S_BF_RD: begin
          step_r  <= '0;
          state_r <= S_BF_MAC;
        end
        S_BF_MAC: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) state_r <= S_BF_WA;
        end
        S_BF_WA: state_r <= S_BF_WB;
        S_BF_WB: begin
          if (idx_r == (nmask >> 1)) begin
            idx_r <= '0;
            if (stage_r == bits_r - LB_W'(1)) state_r <= S_EM_RD;
            else begin
              stage_r <= stage_r + LB_W'(1);
              state_r <= S_BF_RD;
            end
          end else begin
            idx_r   <= idx_r + LOG_MAX'(1);
            state_r <= S_BF_RD;
          end
        end
        S_EM_RD: state_r <= S_EM_LD;
        S_EM_LD: begin
          out_valid_r <= 1'b1;
          bin_re_r    <= inv_r ? DAT_W'(sc_re) : dat_t'(rd_a_r[2*DAT_W-1:DAT_W]);
          bin_im_r    <= inv_r ? DAT_W'(sc_im) : dat_t'(rd_a_r[DAT_W-1:0]);
          bin_index_r <= idx_r;
          last_bin_r  <= (idx_r == nmask);
          state_r     <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (out_s.ready) begin
            out_valid_r <= 1'b0;
            if (last_bin_r) state_r <= S_IDLE;
            else begin
              idx_r   <= idx_r + LOG_MAX'(1);
              state_r <= S_EM_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_s.ready      = (state_r == S_IDLE);
  assign out_s.valid     = out_valid_r;
  assign out_s.bin_re    = bin_re_r;
  assign out_s.bin_im    = bin_im_r;
  assign out_s.bin_index = bin_index_r;
  assign out_s.last_bin  = last_bin_r;

`ifndef SYNTHESIS
  // results are only offered while input is held off
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_s.valid && in_s.ready)) else $error("input ready while bin pending");

  // frame size stays legal while a transform runs
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (bits_r >= LB_W'(1) && bits_r <= LB_W'(LOG_MAX)))
    else $error("frame size out of range");

  // butterfly stage never passes the last stage
  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BF_RD) |-> (stage_r < bits_r)) else $error("stage overrun");

  // a taken last bin returns the block to loading
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && out_s.ready && out_s.last_bin) |=> in_s.ready)
    else $error("no return to load after last bin");
`endif

endmodule

[sv/r2fft_bfly.sv]
// shared butterfly: one multiplier, four multiply-accumulate steps per butterfly
`timescale 1ns / 1ps
module r2fft_bfly
  import r2fft_pkg::*;
(
  input  logic       clk,
  input  bfly_ctrl_t ctrl,
  input  dat_t       ev_re,
  input  dat_t       ev_im,
  input  dat_t       odd_re,
  input  dat_t       odd_im,
  input  tw_t        tw_re,
  input  tw_t        tw_im,
  output dat_t       sum_re,
  output dat_t       sum_im,
  output dat_t       dif_re,
  output dat_t       dif_im
);

  logic signed [ACC_W-1:0]  acc_re_r;
  logic signed [ACC_W-1:0]  acc_im_r;
  dat_t                     op_a;
  tw_t                      op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  rnd_re;
  logic signed [ACC_W-1:0]  rnd_im;
  logic signed [PR_W-1:0]   pr_re;
  logic signed [PR_W-1:0]   pr_im;

  // operand select: re*wr, im*wi, re*wi, im*wr
  assign op_a = ctrl.step[0] ? odd_im : odd_re;
  assign op_b = (ctrl.step == 2'd0 || ctrl.step == 2'd3) ? tw_re : tw_im;
  assign prod = op_a * op_b;

  // accumulate real and imaginary products
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.step)
        2'd0: acc_re_r <= ACC_W'(prod);
        2'd1: acc_re_r <= acc_re_r - ACC_W'(prod);
        2'd2: acc_im_r <= ACC_W'(prod);
        2'd3: acc_im_r <= acc_im_r + ACC_W'(prod);
        default: acc_re_r <= acc_re_r;
      endcase
    end
  end

  // round half up, then add and subtract with saturation
  assign rnd_re = acc_re_r + (ACC_W'(1) <<< (TW_FRAC - 1));
  assign rnd_im = acc_im_r + (ACC_W'(1) <<< (TW_FRAC - 1));
  assign pr_re  = PR_W'(rnd_re >>> TW_FRAC);
  assign pr_im  = PR_W'(rnd_im >>> TW_FRAC);

  assign sum_re = sat_dat(SUM_W'(ev_re) + SUM_W'(pr_re));
  assign sum_im = sat_dat(SUM_W'(ev_im) + SUM_W'(pr_im));
  assign dif_re = sat_dat(SUM_W'(ev_re) - SUM_W'(pr_re));
  assign dif_im = sat_dat(SUM_W'(ev_im) - SUM_W'(pr_im));

endmodule
